### rtl/ets_pkg.sv
`default_nettype none

package ets_pkg;

  // fixed payload widths of the two channels
  localparam int unsigned LIMIT_W     = 17;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

endpackage

`default_nettype wire

### rtl/ets_ram.sv
`default_nettype none

module ets_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read every cycle, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ets_seq.sv
`default_nettype none

module ets_seq
  import ets_pkg::*;
#(
  parameter int unsigned MAX_N       = 65536,
  parameter int unsigned PRIME_SLOTS = 8192,
  parameter int unsigned NW          = $clog2(MAX_N + 1),
  parameter int unsigned TW          = $clog2(MAX_N),
  parameter int unsigned PAW         = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,
  output logic                        tbl_we,
  output logic [NW-1:0]               tbl_waddr,
  output logic [NW+TW-1:0]            tbl_wdata,
  output logic [NW-1:0]               tbl_raddr,
  input  wire logic [NW+TW-1:0]       tbl_rdata,
  output logic                        prm_we,
  output logic [PAW-1:0]              prm_waddr,
  output logic [NW-1:0]               prm_wdata,
  output logic [PAW-1:0]              prm_raddr,
  input  wire logic [NW-1:0]          prm_rdata
);

  localparam int unsigned CW = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned XW = (NW > LIMIT_W) ? NW : LIMIT_W;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_CHK, S_WALK, S_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [NW-1:0]    clr_r, clr_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rd_j_r, rd_j_nxt;
  logic             pv_r, pv_nxt;
  logic             mv_r, mv_nxt;
  logic [2*NW-1:0]  m_r, m_nxt;
  logic [TW+NW-1:0] ph_r, ph_nxt;
  logic [NW-1:0]    p_r, p_nxt;
  logic             eq_r, eq_nxt;
  logic [NW-1:0]    spf_r, spf_nxt;
  logic [TW-1:0]    phi_i_r, phi_i_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             oor_r, oor_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_oor_r, out_oor_nxt;

  logic [XW-1:0]    lim_x;
  logic             lim_oor;
  logic [NW-1:0]    rd_mk;
  logic [TW-1:0]    rd_ph;
  logic             marked;
  logic             store;
  logic [TW-1:0]    phi_cur;
  logic [NW-1:0]    spf_cur;
  logic [NW:0]      i_inc;
  logic             last_i;
  logic [NW-1:0]    fac;
  logic [2*NW-1:0]  m_prod;
  logic [TW+NW-1:0] ph_prod;
  logic             over;
  logic             brk;
  logic             iss;
  logic             walk_end;

  assign lim_x   = XW'(in_tdata[LIMIT_W-1:0]);
  assign lim_oor = lim_x > XW'(MAX_N);

  // table entry: marking prime (zero when unmarked) above phi
  assign rd_mk   = tbl_rdata[NW+TW-1:TW];
  assign rd_ph   = tbl_rdata[TW-1:0];
  assign marked  = rd_mk != '0;
  assign store   = !marked && (cnt_r < CW'(PRIME_SLOTS));
  assign phi_cur = marked ? rd_ph : TW'(i_r - NW'(1));
  // smallest listed prime dividing i, zero if none is listed
  assign spf_cur = marked ? rd_mk : (store ? i_r : '0);

  assign i_inc  = {1'b0, i_r} + (NW+1)'(1);
  assign last_i = i_inc > {1'b0, n_r};

  // product stage, fed straight from the prime list read port
  assign fac     = (prm_rdata == spf_r) ? prm_rdata : prm_rdata - NW'(1);
  assign m_prod  = {{NW{1'b0}}, prm_rdata} * {{NW{1'b0}}, i_r};
  assign ph_prod = {{NW{1'b0}}, phi_i_r} * {{TW{1'b0}}, fac};

  assign over     = m_r > {{NW{1'b0}}, n_r};
  assign brk      = over || eq_r;
  assign iss      = rd_j_r < cnt_r;
  assign walk_end = (mv_r && brk) || (!iss && !pv_r && !mv_r);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_oor_r;
  assign tbl_raddr  = i_nxt;
  assign prm_raddr  = rd_j_r[PAW-1:0];
  assign prm_waddr  = cnt_r[PAW-1:0];
  assign prm_wdata  = i_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    rd_j_nxt      = rd_j_r;
    pv_nxt        = 1'b0;
    mv_nxt        = 1'b0;
    m_nxt         = m_prod;
    ph_nxt        = ph_prod;
    p_nxt         = prm_rdata;
    eq_nxt        = prm_rdata == spf_r;
    spf_nxt       = spf_r;
    phi_i_nxt     = phi_i_r;
    sum_nxt       = sum_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sum_nxt   = out_sum_r;
    out_oor_nxt   = out_oor_r;
    tbl_we        = 1'b0;
    tbl_waddr     = i_r;
    tbl_wdata     = '0;
    prm_we        = 1'b0;
    unique case (state_r)
      S_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        if (clr_r == NW'(MAX_N)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          oor_nxt = lim_oor;
          n_nxt   = lim_x[NW-1:0];
          cnt_nxt = '0;
          i_nxt   = NW'(2);
          sum_nxt = (!lim_oor && lim_x != '0) ? SUM_W'(1) : '0;
          if (lim_oor || lim_x < XW'(2)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        // entry i is final here; clear its mark on the way back
        tbl_we    = 1'b1;
        tbl_waddr = i_r;
        tbl_wdata = {{NW{1'b0}}, phi_cur};
        sum_nxt   = sum_r + SUM_W'(phi_cur);
        phi_i_nxt = phi_cur;
        spf_nxt   = spf_cur;
        if (store) begin
          prm_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        rd_j_nxt  = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        pv_nxt   = iss && !walk_end;
        rd_j_nxt = rd_j_r + CW'(pv_nxt);
        mv_nxt   = pv_r && !walk_end;
        if (mv_r && !over) begin
          tbl_we    = 1'b1;
          tbl_waddr = m_r[NW-1:0];
          tbl_wdata = {p_r, ph_r[TW-1:0]};
        end
        if (walk_end) begin
          if (last_i) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_inc[NW-1:0];
            state_nxt = S_CHK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          out_oor_nxt   = oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      rd_j_r      <= '0;
      pv_r        <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      rd_j_r      <= rd_j_nxt;
      pv_r        <= pv_nxt;
      mv_r        <= mv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    m_r       <= m_nxt;
    ph_r      <= ph_nxt;
    p_r       <= p_nxt;
    eq_r      <= eq_nxt;
    spf_r     <= spf_nxt;
    phi_i_r   <= phi_i_nxt;
    sum_r     <= sum_nxt;
    oor_r     <= oor_nxt;
    out_sum_r <= out_sum_nxt;
    out_oor_r <= out_oor_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PRIME_SLOTS))
    else $error("prime count beyond list size");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> rd_j_r <= cnt_r)
    else $error("prime walk index past list end");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    mv_r |-> $past(pv_r))
    else $error("product stage valid without a prime read");

  a_i_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> (i_r >= NW'(2) && i_r <= n_r))
    else $error("sieve index outside 2..n");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("finished result not presented");

endmodule

`default_nettype wire

### rtl/euler_totient_sum_sieve_core.sv
`default_nettype none

// channel | ports                         | contents (low bit up)
// in      | in_tvalid/in_tready/in_tdata  | tdata[16:0] limit, [23:17] zero
// out     | out_tvalid/out_tready/...     | tdata[31:0] totient_sum, tuser out_of_range
//
// after reset a clearing pass zeroes all MAX_N+1 totient table entries; in_tready stays low
// a request with limit n >= 2 visits each number 2..n in a check state, then walks the
// prime list through the prime-list read, product stage and table write-back loop,
// marking composites until a product passes n or the walk reaches the smallest prime factor
// limit 0, 1 or above MAX_N goes straight to the result without a sieve pass
// one request at a time; a finished result waits in the output register while the
// next request is taken, and the sieve stalls in its last state if that register is full

module euler_totient_sum_sieve_core
  import ets_pkg::*;
#(
  parameter int unsigned MAX_N       = 65536,
  parameter int unsigned PRIME_SLOTS = 8192
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [16:0] limit
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [31:0] totient_sum
  output logic                        out_tuser   // [0] out_of_range
);

  localparam int unsigned NW  = $clog2(MAX_N + 1);
  localparam int unsigned TW  = $clog2(MAX_N);
  localparam int unsigned PAW = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;

  logic             tbl_we;
  logic [NW-1:0]    tbl_waddr;
  logic [NW+TW-1:0] tbl_wdata;
  logic [NW-1:0]    tbl_raddr;
  logic [NW+TW-1:0] tbl_rdata;
  logic             prm_we;
  logic [PAW-1:0]   prm_waddr;
  logic [NW-1:0]    prm_wdata;
  logic [PAW-1:0]   prm_raddr;
  logic [NW-1:0]    prm_rdata;

  ets_seq #(
    .MAX_N       (MAX_N),
    .PRIME_SLOTS (PRIME_SLOTS),
    .NW          (NW),
    .TW          (TW),
    .PAW         (PAW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .tbl_we     (tbl_we),
    .tbl_waddr  (tbl_waddr),
    .tbl_wdata  (tbl_wdata),
    .tbl_raddr  (tbl_raddr),
    .tbl_rdata  (tbl_rdata),
    .prm_we     (prm_we),
    .prm_waddr  (prm_waddr),
    .prm_wdata  (prm_wdata),
    .prm_raddr  (prm_raddr),
    .prm_rdata  (prm_rdata)
  );

  // totient table with marking prime per entry
  ets_ram #(
    .DEPTH (MAX_N + 1),
    .WIDTH (NW + TW),
    .AW    (NW)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  ets_ram #(
    .DEPTH (PRIME_SLOTS),
    .WIDTH (NW),
    .AW    (PAW)
  ) u_prm (
    .clk   (clk),
    .we    (prm_we),
    .waddr (prm_waddr),
    .wdata (prm_wdata),
    .raddr (prm_raddr),
    .rdata (prm_rdata)
  );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ets_pkg::*;

  localparam int unsigned MAX_LIMIT  = 65536;
  localparam int unsigned PRIME_CAP  = 8192;
  localparam int unsigned DIR_ROWS   = 23;
  localparam int unsigned RAND_ITEMS = 100;
  localparam int unsigned LONG_HOLD  = 3000;
  localparam int unsigned LIMIT_TOP  = (1 << LIMIT_W) - 1;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             oor;
  } totient_ans_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               typed;
    logic [SUM_W-1:0]   sum;
    logic               oor;
  } req_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  euler_totient_sum_sieve_core #(
    .MAX_N      (MAX_LIMIT),
    .PRIME_SLOTS(PRIME_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: linear sieve tables
  logic [15:0]  phi_tab   [0:MAX_LIMIT];
  bit           comp_map  [0:MAX_LIMIT];
  logic [15:0]  prime_tab [0:PRIME_CAP-1];
  int unsigned  prime_cnt;

  totient_ans_t pending_ans[$];
  req_row_t     dir_rows [DIR_ROWS];

  int unsigned  bad_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  oor_sent = 0;
  int unsigned  full_sent = 0;
  bit           calm = 1'b0;
  bit           send_quiet = 1'b0;
  bit           hold_req = 1'b0;
  bit           hold_done = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  burst_left = 0;
  int unsigned  mode_left = 0;
  bit           sink_quiet = 1'b0;

  function automatic totient_ans_t totient_answer(input logic [LIMIT_W-1:0] lim);
    totient_ans_t ans;
    int unsigned  n;
    int unsigned  i;
    int unsigned  j;
    int unsigned  p;
    int unsigned  m;
    n = 32'(lim);
    ans.sum = '0;
    ans.oor = 1'b0;
    if (n > MAX_LIMIT) begin
      ans.oor = 1'b1;
      return ans;
    end
    for (i = 0; i <= n; i++) comp_map[i] = 1'b0;
    prime_cnt = 0;
    if (n == 0) return ans;
    phi_tab[1] = 16'd1;
    for (i = 2; i <= n; i++) begin
      if (!comp_map[i]) begin
        // a full prime list still gets phi, just not stored
        if (prime_cnt < PRIME_CAP) begin
          prime_tab[prime_cnt] = i[15:0];
          prime_cnt++;
        end
        phi_tab[i] = 16'(i - 1);
      end
      for (j = 0; j < prime_cnt; j++) begin
        p = 32'(prime_tab[j]);
        m = p * i;
        if (m > n) break;
        comp_map[m] = 1'b1;
        if (i % p == 0) begin
          phi_tab[m] = 16'(p * 32'(phi_tab[i]));
          break;
        end
        phi_tab[m] = 16'(32'(phi_tab[i]) * (p - 1));
      end
    end
    for (i = 1; i <= n; i++) ans.sum += SUM_W'(phi_tab[i]);
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input totient_ans_t exp_ans,
                                 input totient_ans_t got_ans);
    bad_count++;
    if (bad_count <= 10)
      $display("mismatch (%s) at %0t: expected sum %0d oor %0b, got sum %0d oor %0b",
               what, $realtime, exp_ans.sum, exp_ans.oor, got_ans.sum, got_ans.oor);
  endtask

  task automatic offer_request(input logic [LIMIT_W-1:0] lim, input logic typed,
                               input totient_ans_t typed_ans);
    int unsigned gap;
    if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
    if (!calm && !send_quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(IN_TDATA_W - LIMIT_W){1'b0}}, lim};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (32'(lim) > MAX_LIMIT) oor_sent++;
    if (32'(lim) == MAX_LIMIT) full_sent++;
    if (typed) pending_ans.push_back(typed_ans);
    else pending_ans.push_back(totient_answer(lim));
  endtask

  // result checker
  always @(posedge clk) begin
    totient_ans_t got_ans;
    totient_ans_t exp_ans;
    if (rst_n && out_tvalid && out_tready) begin
      got_ans.sum = out_tdata[SUM_W-1:0];
      got_ans.oor = out_tuser;
      results_seen++;
      if (pending_ans.size() == 0) begin
        report_mismatch("no request pending", '0, got_ans);
      end else begin
        exp_ans = pending_ans.pop_front();
        if (got_ans.sum !== exp_ans.sum || got_ans.oor !== exp_ans.oor)
          report_mismatch("field", exp_ans, got_ans);
      end
    end
  end

  // receiver: one long hold-off, otherwise random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_quiet = 1'($urandom_range(0, 1));
        mode_left  = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (!calm && !sink_quiet && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 16) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [LIMIT_W-1:0] lim;
    totient_ans_t       row_ans;
    int unsigned        big_at;
    int unsigned        pick;
    dir_rows = '{
      '{17'd0,      1'b1, 32'd0, 1'b0},
      '{17'd1,      1'b1, 32'd1, 1'b0},
      '{17'd2,      1'b1, 32'd2, 1'b0},
      '{17'd3,      1'b0, 32'd0, 1'b0},
      '{17'd4,      1'b0, 32'd0, 1'b0},
      '{17'd5,      1'b0, 32'd0, 1'b0},
      '{17'd6,      1'b0, 32'd0, 1'b0},
      '{17'd7,      1'b0, 32'd0, 1'b0},
      '{17'd8,      1'b0, 32'd0, 1'b0},
      '{17'd9,      1'b0, 32'd0, 1'b0},
      '{17'd10,     1'b0, 32'd0, 1'b0},
      '{17'd16,     1'b0, 32'd0, 1'b0},
      '{17'd30,     1'b0, 32'd0, 1'b0},
      '{17'd97,     1'b0, 32'd0, 1'b0},
      '{17'd128,    1'b0, 32'd0, 1'b0},
      '{17'd255,    1'b0, 32'd0, 1'b0},
      '{17'd1000,   1'b0, 32'd0, 1'b0},
      '{17'd65536,  1'b0, 32'd0, 1'b0},
      '{17'd65537,  1'b1, 32'd0, 1'b1},
      '{17'd131071, 1'b1, 32'd0, 1'b1},
      '{17'd87381,  1'b1, 32'd0, 1'b1},
      // out-of-range request must leave the sieve usable
      '{17'd0,      1'b1, 32'd0, 1'b0},
      '{17'd2,      1'b1, 32'd2, 1'b0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      row_ans.sum = dir_rows[r].sum;
      row_ans.oor = dir_rows[r].oor;
      offer_request(dir_rows[r].limit, dir_rows[r].typed, row_ans);
    end

    // sink holds off while small requests keep coming
    hold_req = 1'b1;
    big_at = $urandom_range(20, 80);
    for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
      calm = (k >= RAND_ITEMS - 10);
      pick = $urandom_range(0, 99);
      if (k == big_at) lim = LIMIT_W'(MAX_LIMIT);
      else if (k < 10 || pick >= 28) lim = LIMIT_W'($urandom_range(2, 400));
      else if (pick < 15) lim = LIMIT_W'($urandom_range(MAX_LIMIT + 1, LIMIT_TOP));
      else if (pick < 20) lim = LIMIT_W'($urandom_range(0, 1));
      else lim = LIMIT_W'($urandom_range(401, 4000));
      offer_request(lim, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_ans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d directed and %0d random requests, %0d out of range, %0d at full size",
             DIR_ROWS, RAND_ITEMS, oor_sent, full_sent);
    $display("checked %0d results, %0d mismatches", results_seen, bad_count);
    if (bad_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_ans.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
